// File: design/bba_pkg.sv
// Shared constants, types and helpers of the bitmap block allocator.
package bba_pkg;

  // MAP_WORD_BITS must be a power of two.
  localparam int BLOCK_COUNT      = 32768;
  localparam int BLOCK_BYTES_LOG2 = 12;
  localparam int MAP_WORD_BITS    = 32;

  localparam int MAP_WORDS = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);

  localparam int OP_W   = 2;
  localparam int IDX_W  = 15;
  localparam int ADDR_W = 27;
  localparam int BLK_W  = (($clog2(BLOCK_COUNT) > IDX_W) ? $clog2(BLOCK_COUNT) : IDX_W) + 1;
  localparam int WIDE_W = BLK_W + BLOCK_BYTES_LOG2 + ADDR_W;

  localparam int IN_TDATA_W  = ((OP_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + IDX_W + ADDR_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_TEST  = 2'd3
  } op_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_t;

  function automatic logic [ADDR_W-1:0] blk_addr(input logic [BLK_W-1:0] b);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(b) << BLOCK_BYTES_LOG2;
    return wide[ADDR_W-1:0];
  endfunction

endpackage

// File: design/bitmap_block_allocator_top.sv
// Bitmap block allocator: one used/free bit per memory block, held in a single map RAM.
// Each request is handled alone. Mark, free and test read the map word at the accepting
// edge, then load the result and, for mark and free, write the word back once the output
// register is free. Allocate reads one map word per cycle through the RAM's read port,
// starting at word 0, until it finds a clear bit or reaches the last word. in_tready is
// high again in the cycle after a result is loaded, so a request is not taken before the
// last one's result is loaded. After reset the block writes every map word to all ones,
// one word a cycle, and in_tready stays low until the last word is written.
// A finished result waits in the output register while the next request is taken.
module bitmap_block_allocator_top import bba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // opcode[1:0], block_index[16:2], zero fill above.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[0], result_block[15:1], block_address[42:16], was_used[43], zero fill above.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [3:0] {
    ST_INIT = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_READ = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

  typedef struct packed {
    logic              was_used;
    logic [ADDR_W-1:0] block_address;
    logic [IDX_W-1:0]  result_block;
    logic              status;
  } out_res_t;

  state_t             st_r, st_nxt;
  op_t                op_r;
  logic [BLK_W-1:0]   idx_r;
  logic [WADDR_W-1:0] cur_r, cur_nxt;
  logic [WADDR_W-1:0] clr_r;
  map_word_t          rd_data_r;
  map_word_t          mem [MAP_WORDS];
  out_res_t           out_res_r, res;
  logic               out_tvalid_r;

  logic               mem_we;
  logic [WADDR_W-1:0] mem_waddr, mem_raddr;
  map_word_t          mem_wdata;
  logic               out_load;

  op_t                in_op;
  logic [BLK_W-1:0]   in_idx;
  logic               in_acc;
  logic               out_free;
  logic               last_word;
  logic               idx_ok;
  logic [BIT_W-1:0]   idx_bit;
  logic [BLK_W-1:0]   alloc_blk;
  ffz_t               ffz;

  assign in_op     = op_t'(in_tdata[OP_W-1:0]);
  assign in_idx    = BLK_W'(in_tdata[OP_W +: IDX_W]);
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign last_word = (cur_r == WADDR_W'(MAP_WORDS - 1));
  assign idx_ok    = (idx_r < BLK_W'(BLOCK_COUNT));
  assign idx_bit   = idx_r[BIT_W-1:0];
  assign alloc_blk = (BLK_W'(cur_r) << BIT_W) | BLK_W'(ffz.pos);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

  bba_ffz u_ffz (
    .word (rd_data_r),
    .res  (ffz)
  );

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = rd_data_r;
    mem_raddr = cur_r;
    out_load  = 1'b0;
    res       = '0;
    unique case (st_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '1;
        if (clr_r == WADDR_W'(MAP_WORDS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = (in_op == OP_ALLOC) ? '0 : in_idx[BIT_W +: WADDR_W];
        if (in_acc) begin
          cur_nxt = mem_raddr;
          st_nxt  = (in_op == OP_ALLOC) ? ST_SCAN : ST_READ;
        end
      end
      ST_READ: begin
        res.status        = 1'b0;
        res.result_block  = idx_r[IDX_W-1:0];
        res.block_address = blk_addr(idx_r);
        res.was_used      = !idx_ok || rd_data_r[idx_bit];
        if (op_r == OP_MARK) begin
          mem_wdata = rd_data_r | (map_word_t'(1) << idx_bit);
        end else begin
          mem_wdata = rd_data_r & ~(map_word_t'(1) << idx_bit);
        end
        if (out_free) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
          mem_we   = idx_ok && ((op_r == OP_MARK) || (op_r == OP_FREE));
        end
      end
      ST_SCAN: begin
        if (ffz.found) begin
          res.status        = 1'b0;
          res.result_block  = alloc_blk[IDX_W-1:0];
          res.block_address = blk_addr(alloc_blk);
          res.was_used      = 1'b0;
          mem_wdata         = rd_data_r | (map_word_t'(1) << ffz.pos);
          if (out_free) begin
            out_load = 1'b1;
            mem_we   = 1'b1;
            st_nxt   = ST_IDLE;
          end
        end else if (last_word) begin
          res.status   = 1'b1;
          res.was_used = 1'b1;
          if (out_free) begin
            out_load = 1'b1;
            st_nxt   = ST_IDLE;
          end
        end else begin
          mem_raddr = cur_r + WADDR_W'(1);
          cur_nxt   = mem_raddr;
        end
      end
      default: begin
        st_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_INIT;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_INIT) begin
        clr_r <= clr_r + WADDR_W'(1);
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (in_acc) begin
      op_r  <= in_op;
      idx_r <= in_idx;
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_res_r.status |->
      out_res_r.was_used && (out_res_r.block_address == '0) && (out_res_r.result_block == '0))
    else $error("Failed allocate carries nonzero fields.");

  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && (st_r != ST_INIT) |-> out_free && out_load)
    else $error("Map write without a result being loaded.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (cur_r <= WADDR_W'(MAP_WORDS - 1)))
    else $error("Allocate scan ran past the last map word.");
`endif

endmodule

// File: design/bba_ffz.sv
// Finds the lowest clear bit of one usage map word.
module bba_ffz import bba_pkg::*; (
  input  map_word_t word,
  output ffz_t      res
);

  always_comb begin
    res.found = ~&word;
    res.pos   = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.pos = BIT_W'(i);
      end
    end
  end

endmodule

// File: test/tb.sv
// Self-checking stream testbench for the bitmap block allocator with a built-in map predictor.
module tb;
  import bba_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 186;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } request_t;

  typedef struct packed {
    logic              status;
    logic [IDX_W-1:0]  blk;
    logic [ADDR_W-1:0] addr;
    logic              was_used;
  } grant_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  request_t  pending_requests[$];
  grant_t    expected_grants[$];
  map_word_t usage_words[MAP_WORDS];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase         = 0;
  int hold_left     = 0;
  bit held          = 1'b0;
  bit in_taken      = 1'b0;
  int errors        = 0;
  int cycles        = 0;
  int n_alloc_ok    = 0;
  int n_alloc_full  = 0;
  int n_mark        = 0;
  int n_free        = 0;
  int n_test        = 0;

  bitmap_block_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void set_usage(input int b, input bit used);
    if (b < BLOCK_COUNT) begin
      usage_words[b / MAP_WORD_BITS][b % MAP_WORD_BITS] = used;
    end
  endfunction

  function automatic grant_t predict_grant(input request_t req);
    grant_t      g;
    int          b;
    logic [63:0] wide;
    g = '0;
    if (req.op == OP_ALLOC) begin
      b = -1;
      for (int w = 0; w < MAP_WORDS && b < 0; w++) begin
        if (usage_words[w] != '1) begin
          for (int k = 0; k < MAP_WORD_BITS && b < 0; k++) begin
            if (!usage_words[w][k] && w * MAP_WORD_BITS + k < BLOCK_COUNT) begin
              b = w * MAP_WORD_BITS + k;
            end
          end
        end
      end
      if (b < 0) begin
        g.status   = 1'b1;
        g.was_used = 1'b1;
        n_alloc_full++;
        return g;
      end
      set_usage(b, 1'b1);
      n_alloc_ok++;
    end else begin
      b = int'(req.idx);
      g.was_used = (b < BLOCK_COUNT) ? usage_words[b / MAP_WORD_BITS][b % MAP_WORD_BITS] : 1'b1;
      case (req.op)
        OP_MARK: begin
          set_usage(b, 1'b1);
          n_mark++;
        end
        OP_FREE: begin
          set_usage(b, 1'b0);
          n_free++;
        end
        default: begin
          n_test++;
        end
      endcase
    end
    wide   = 64'(b) << BLOCK_BYTES_LOG2;
    g.blk  = b[IDX_W-1:0];
    g.addr = wide[ADDR_W-1:0];
    return g;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at cycle %0d, %s: got 0x%0h, expected 0x%0h", cycles, what, got, want);
    errors++;
  endtask

  // Request driver.
  always @(negedge clk) begin
    request_t req;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        in_tdata  <= IN_TDATA_W'({req.idx, req.op});
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off once the sender runs without gaps.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (phase == 3 && !held && out_tvalid) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      held       <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin
    request_t req;
    grant_t   got;
    grant_t   want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      req.op  = op_t'(in_tdata[OP_W-1:0]);
      req.idx = in_tdata[OP_W+IDX_W-1:OP_W];
      expected_grants.push_back(predict_grant(req));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = out_tdata[0];
      got.blk      = out_tdata[IDX_W:1];
      got.addr     = out_tdata[IDX_W+ADDR_W:IDX_W+1];
      got.was_used = out_tdata[IDX_W+ADDR_W+1];
      if (expected_grants.size() == 0) begin
        report_mismatch("result with no request outstanding", 64'(out_tdata), 64'(0));
      end else begin
        want = expected_grants.pop_front();
        if (got.status !== want.status) begin
          report_mismatch("status", 64'(got.status), 64'(want.status));
        end
        if (got.blk !== want.blk) begin
          report_mismatch("result_block", 64'(got.blk), 64'(want.blk));
        end
        if (got.addr !== want.addr) begin
          report_mismatch("block_address", 64'(got.addr), 64'(want.addr));
        end
        if (got.was_used !== want.was_used) begin
          report_mismatch("was_used", 64'(got.was_used), 64'(want.was_used));
        end
      end
    end
  end

  task automatic queue_request(input op_t op, input logic [IDX_W-1:0] idx);
    request_t req;
    req.op  = op;
    req.idx = idx;
    pending_requests.push_back(req);
  endtask

  task automatic queue_random_requests(input int count, input int window_base);
    int               pick;
    op_t              op;
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      pick = $urandom_range(99);
      op   = (pick < 35) ? OP_FREE : (pick < 65) ? OP_ALLOC : (pick < 80) ? OP_MARK : OP_TEST;
      pick = $urandom_range(99);
      if (pick < 60) begin
        idx = IDX_W'(window_base + $urandom_range(255));
      end else if (pick < 88) begin
        idx = IDX_W'($urandom);
      end else begin
        idx = $urandom_range(1) ? '1 : '0;
      end
      queue_request(op, idx);
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (pending_requests.size() != 0 || (in_tvalid && !in_taken) ||
               expected_grants.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) begin
      usage_words[w] = '1;
    end
    send_idle_pct = 14;
    recv_idle_pct = 87;
    phase         = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The map starts full, so the first allocation must fail.
    queue_request(OP_ALLOC, '0);
    queue_request(OP_TEST, '0);
    queue_request(OP_TEST, '1);
    queue_request(OP_FREE, '0);
    queue_request(OP_FREE, '1);
    queue_request(OP_FREE, 15'h2AAA);
    queue_request(OP_FREE, 15'h5555);
    queue_request(OP_TEST, '0);
    queue_request(OP_ALLOC, '1);
    queue_request(OP_ALLOC, 15'h2AAA);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_MARK, 15'd100);
    queue_request(OP_FREE, 15'd100);
    queue_request(OP_FREE, 15'd100);
    queue_request(OP_MARK, 15'd100);
    queue_request(OP_TEST, 15'd100);
    queue_request(OP_FREE, 15'd31);
    queue_request(OP_FREE, 15'd32);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_TEST, '1);
    wait_idle();

    queue_random_requests(PHASE_ITEMS, 0);
    wait_idle();

    send_idle_pct = 87;
    recv_idle_pct = 14;
    phase         = 2;
    queue_random_requests(PHASE_ITEMS, $urandom_range(BLOCK_COUNT - 256));
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase         = 3;
    queue_random_requests(PHASE_ITEMS, $urandom_range(BLOCK_COUNT - 256));
    wait_idle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_grants.size() != 0 || pending_requests.size() != 0) begin
      report_mismatch("requests left without a result", 64'(expected_grants.size()), 64'(0));
    end
    $display("Covered %0d allocations (%0d on a full map), %0d marks, %0d frees, %0d tests.",
             n_alloc_ok + n_alloc_full, n_alloc_full, n_mark, n_free, n_test);
    $display("Ran with heavy output stalls, heavy input gaps, no gaps and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
